// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define C8WD_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("c8wd assertion failed");

// Clocked assertion that also holds during reset.
`define C8WD_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("c8wd assertion failed");

`endif

// ===== design/c8wd_pkg.sv =====
// Package: constants, types and the CRC-8 byte update for the word deframer.
`default_nettype none

package c8wd_pkg;

    localparam int MAX_WORDS_DEF = 32;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Position within the byte triple
    typedef enum logic [1:0] {
        PH_HIGH  = 2'd0,
        PH_LOW   = 2'd1,
        PH_CHECK = 2'd2
    } phase_t;

    // MSB-first CRC-8 update over one byte, no final xor
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/c8wd_crc8.sv =====
// Byte-wide CRC-8 (poly 0x31) next-value logic.
`default_nettype none

module c8wd_crc8 (
    input  wire logic [7:0] crc_in,
    input  wire logic [7:0] data_in,
    output logic      [7:0] crc_out
);

    assign crc_out = c8wd_pkg::crc8_feed(crc_in, data_in);

endmodule

`default_nettype wire

// ===== design/crc8_word_deframer.sv =====
// Top level: CRC-8 checked word deframer for a byte stream in threes.
// Path: a check byte passes the input register; its word then goes to the result register.
// Throughput: one byte per cycle while m_axis is not stalled; set by the byte-wide CRC
//   update between the input register and the result register.
// Reset (rst_n, async, low): both stages empty, transfer closed, CRC = 0xFF,
//   word target = 1; bytes are dropped until one arrives marked as frame start.
`default_nettype none

module crc8_word_deframer #(
    parameter int MAX_WORDS = c8wd_pkg::MAX_WORDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [13:8] words_expected, rest 0
    input  wire logic        s_axis_tuser,   // [0] frame_start

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [15:0] data_word
    output logic             m_axis_tlast,   // last_word
    output logic       [1:0] m_axis_tuser    // [0] crc_good, [1] status
);

    // Word counter wide enough to hold MAX_WORDS itself
    localparam int CntW = $clog2(MAX_WORDS + 1);
    // Compare width covers both the 6-bit request and the counter
    localparam int CmpW = (CntW > 6) ? CntW : 6;

    // ---------------- input register stage ----------------
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [5:0]  in_want_reg;
    logic        in_start_reg;

    logic        advance;   // input stage item is processed this cycle

    assign advance       = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata[7:0];
            in_want_reg  <= s_axis_tdata[13:8];
            in_start_reg <= s_axis_tuser;
        end
    end

    // ---------------- deframer state ----------------
    c8wd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       hi_reg, hi_next;
    logic [7:0]       lo_reg, lo_next;
    logic [CntW-1:0]  done_reg, done_next;
    logic [CntW-1:0]  target_reg, target_next;
    logic             closed_reg, closed_next;

    // result register
    logic             out_valid_next;
    logic [15:0]      out_word_reg;
    logic             out_good_reg;
    logic             out_last_reg;

    // working values after a frame start is applied
    c8wd_pkg::phase_t cur_phase;
    logic [7:0]       cur_crc;
    logic [CntW-1:0]  cur_done;
    logic [CntW-1:0]  cur_target;
    logic             cur_closed;

    logic [CmpW-1:0]  want_ext;
    logic [CmpW-1:0]  want_sat;
    logic [7:0]       crc_upd;
    logic [CntW-1:0]  done_inc;
    logic             good;
    logic             last;
    logic             emit;

    // Requested word count: zero means one, above MAX_WORDS saturates
    always_comb
    begin
        want_ext = CmpW'(in_want_reg);
        if (want_ext == '0)
            want_sat = CmpW'(1);
        else if (want_ext > CmpW'(MAX_WORDS))
            want_sat = CmpW'(MAX_WORDS);
        else
            want_sat = want_ext;
    end

    c8wd_crc8 u_crc (
        .crc_in  (cur_crc),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        // frame start restarts the transfer before the byte is looked at
        if (in_start_reg)
        begin
            cur_phase  = c8wd_pkg::PH_HIGH;
            cur_crc    = c8wd_pkg::CRC_INIT;
            cur_done   = '0;
            cur_target = CntW'(want_sat);
            cur_closed = 1'b0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_crc    = crc_reg;
            cur_done   = done_reg;
            cur_target = target_reg;
            cur_closed = closed_reg;
        end

        done_inc = cur_done + CntW'(1);
        good     = (in_byte_reg == cur_crc);
        last     = !good || (done_inc >= cur_target);

        phase_next  = phase_reg;
        crc_next    = crc_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        done_next   = done_reg;
        target_next = target_reg;
        closed_next = closed_reg;
        emit        = 1'b0;

        if (advance)
        begin
            phase_next  = cur_phase;
            crc_next    = cur_crc;
            done_next   = cur_done;
            target_next = cur_target;
            closed_next = cur_closed;

            if (!cur_closed)
            begin
                unique case (cur_phase)
                    c8wd_pkg::PH_HIGH:
                    begin
                        hi_next    = in_byte_reg;
                        crc_next   = crc_upd;
                        phase_next = c8wd_pkg::PH_LOW;
                    end
                    c8wd_pkg::PH_LOW:
                    begin
                        lo_next    = in_byte_reg;
                        crc_next   = crc_upd;
                        phase_next = c8wd_pkg::PH_CHECK;
                    end
                    c8wd_pkg::PH_CHECK:
                    begin
                        emit        = 1'b1;
                        done_next   = done_inc;
                        closed_next = last;
                        phase_next  = c8wd_pkg::PH_HIGH;
                        crc_next    = c8wd_pkg::CRC_INIT;
                    end
                    default:
                    begin
                        phase_next = c8wd_pkg::PH_HIGH;
                    end
                endcase
            end
        end

        // result register: load on a new word, clear once taken
        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = m_axis_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= c8wd_pkg::PH_HIGH;
            crc_reg       <= c8wd_pkg::CRC_INIT;
            hi_reg        <= '0;
            lo_reg        <= '0;
            done_reg      <= '0;
            target_reg    <= CntW'(1);
            closed_reg    <= 1'b1;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            done_reg      <= done_next;
            target_reg    <= target_next;
            closed_reg    <= closed_next;
            m_axis_tvalid <= out_valid_next;
        end
    end

    // Result payload; status is the inverse of crc_good
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= {hi_reg, lo_reg};
            out_good_reg <= good;
            out_last_reg <= last;
        end
    end

    assign m_axis_tdata = out_word_reg;
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tuser = {!out_good_reg, out_good_reg};

endmodule

`default_nettype wire

// ===== design/c8wd_checker.sv =====
// Port-level checker for the word deframer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module c8wd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic  [1:0] m_axis_tuser
);

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata, s_axis_tuser, m_axis_tdata, m_axis_tready};

    // No word is offered while held in reset
    `C8WD_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |-> !m_axis_tvalid)

    // status is always the inverse of crc_good
    `C8WD_ASSERT(a_status_inv, clk, rst_n, m_axis_tvalid |-> (m_axis_tuser[1] == !m_axis_tuser[0]))

    // An error word always closes the transfer
    `C8WD_ASSERT(a_err_last, clk, rst_n, (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)

    // A new word must follow a byte accepted on s_axis
    `C8WD_ASSERT(a_latency, clk, rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind crc8_word_deframer c8wd_checker u_c8wd_checker (.*);

`default_nettype wire
